@@ sv/dtwp_pkg.sv @@
// shared constants and pipeline types for the depth to world point unit
package dtwp_pkg;

  localparam int MAX_COLUMNS = 4096;
  localparam int MAX_ROWS    = 4096;

  localparam int DIV_STEPS = 37;  // one quotient bit per cell, z is Q21.16
  localparam int REM_W     = 25;
  localparam int D_W       = 24;
  localparam int A_W       = 46;  // s*coord + o in Q.30
  localparam int CAM_W     = 40;  // camera coordinates, Q24.16
  localparam int WORLD_W   = 32;

  typedef struct packed {
    logic signed [A_W-1:0] ax;
    logic signed [A_W-1:0] ay;
    logic                  clr;
    logic [7:0]            blue;
    logic [7:0]            green;
    logic [7:0]            red;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]     rem;
    logic [D_W-1:0]       d;
    logic [DIV_STEPS-1:0] q;
    side_t                side;
  } div_t;

endpackage

@@ sv/dtwp_div_cell.sv @@
// one restoring division cell: one quotient bit of 2^36 / d per cycle while en is high
module dtwp_div_cell import dtwp_pkg::*; (
  input  logic clk,
  input  logic en,
  input  div_t cur,
  output div_t res
);

  div_t             res_nxt;
  div_t             res_r;
  logic             ge;
  logic [REM_W-1:0] diff;

  always_comb begin
    ge          = cur.rem >= {1'b0, cur.d};
    diff        = cur.rem - {1'b0, cur.d};
    res_nxt     = cur;
    res_nxt.q   = {cur.q[DIV_STEPS-2:0], ge};
    // remainder stays below d, so the shift never loses a set bit
    res_nxt.rem = ge ? {diff[REM_W-2:0], 1'b0} : {cur.rem[REM_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ sv/dtwp_backproj.sv @@
// back-projection of one axis: round(a*z) to Q.16, saturated to 40 bits
module dtwp_backproj import dtwp_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [A_W-1:0]   a,
  input  logic [DIV_STEPS-1:0]    z,
  output logic signed [CAM_W-1:0] cam
);

  localparam int HALF_W = A_W / 2;
  localparam int P_W    = HALF_W + DIV_STEPS;
  localparam int S_W    = A_W + DIV_STEPS;

  logic                    neg1_r, neg2_r;
  logic [A_W-1:0]          mag1_r;
  logic [DIV_STEPS-1:0]    z1_r;
  logic [P_W-1:0]          plo_r, phi_r;
  logic [S_W-1:0]          sum;
  logic [S_W-31:0]         rnd;
  logic                    over;
  logic signed [CAM_W-1:0] cam_nxt, cam_r;

  always_comb begin
    sum  = {{HALF_W{1'b0}}, plo_r} + {phi_r, {HALF_W{1'b0}}} + (S_W'(1) << 29);
    rnd  = sum[S_W-1:30];
    over = |rnd[S_W-31:CAM_W-1];
    if (neg2_r) begin
      cam_nxt = over ? {1'b1, {(CAM_W-1){1'b0}}} : -$signed(rnd[CAM_W-1:0]);
    end else begin
      cam_nxt = over ? {1'b0, {(CAM_W-1){1'b1}}} : $signed(rnd[CAM_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= a[A_W-1];
      mag1_r <= a[A_W-1] ? A_W'(-a) : A_W'(a);
      z1_r   <= z;
      // magnitude split in two halves, each product registered
      plo_r  <= mag1_r[HALF_W-1:0] * z1_r;
      phi_r  <= mag1_r[A_W-1:HALF_W] * z1_r;
      neg2_r <= neg1_r;
      cam_r  <= cam_nxt;
    end
  end

  assign cam = cam_r;

endmodule

@@ sv/dtwp_transform.sv @@
// one world axis: rotation row times camera point plus translation, Q16.16
module dtwp_transform import dtwp_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic [47:0]               row,
  input  logic [19:0]               tr,
  input  logic signed [CAM_W-1:0]   cam_x,
  input  logic signed [CAM_W-1:0]   cam_y,
  input  logic signed [CAM_W-1:0]   cam_z,
  output logic signed [WORLD_W-1:0] world
);

  localparam int M_W   = CAM_W + 16;
  localparam int ACC_W = M_W + 4;

  localparam logic signed [ACC_W-15:0] SAT_HI = (ACC_W-14)'(64'sd2147483647);
  localparam logic signed [ACC_W-15:0] SAT_LO = -((ACC_W-14)'(64'sd2147483648));

  logic signed [M_W-1:0]     m0_r, m1_r, m2_r;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-15:0]  sh;
  logic signed [WORLD_W-1:0] world_nxt, world_r;

  always_comb begin
    acc = ACC_W'(m0_r) + ACC_W'(m1_r) + ACC_W'(m2_r)
        + (ACC_W'($signed(tr)) <<< 18) + ACC_W'(8192);
    sh  = acc[ACC_W-1:14];
    if (sh > SAT_HI) begin
      world_nxt = {1'b0, {(WORLD_W-1){1'b1}}};
    end else if (sh < SAT_LO) begin
      world_nxt = {1'b1, {(WORLD_W-1){1'b0}}};
    end else begin
      world_nxt = sh[WORLD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0_r    <= $signed(row[15:0])  * cam_x;
      m1_r    <= $signed(row[31:16]) * cam_y;
      m2_r    <= $signed(row[47:32]) * cam_z;
      world_r <= world_nxt;
    end
  end

  assign world = world_r;

endmodule

@@ sv/depth_to_world_point.sv @@
// top level of the depth to world point unit
// pipeline: entry stage, 37 divider cells, 3 back-projection stages,
//   2 transform stages, output reg
// throughput: one item per cycle while the skid register is empty, every stage is a single register
// a skid register lets one item in while a result waits at the output
// reset: valid bits clear, registers take their defaults (unit intrinsics,
//   identity rotation, zero translation and threshold)
module depth_to_world_point_unit import dtwp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [11:0]               in_pixel_column,
  input  logic [11:0]               in_pixel_row,
  input  logic [23:0]               in_inverse_depth,
  input  logic [7:0]                in_color_blue,
  input  logic [7:0]                in_color_green,
  input  logic [7:0]                in_color_red,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [WORLD_W-1:0] out_world_x,
  output logic signed [WORLD_W-1:0] out_world_y,
  output logic signed [WORLD_W-1:0] out_world_z,
  output logic [7:0]                out_blue,
  output logic [7:0]                out_green,
  output logic [7:0]                out_red,
  output logic                      out_depth_cleared,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [5:0]                paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready
);

  // register map, 8 bytes apart
  localparam logic [2:0] REG_INTR_X = 3'd0;
  localparam logic [2:0] REG_INTR_Y = 3'd1;
  localparam logic [2:0] REG_MIN_ID = 3'd2;
  localparam logic [2:0] REG_ROT0   = 3'd3;
  localparam logic [2:0] REG_ROT1   = 3'd4;
  localparam logic [2:0] REG_ROT2   = 3'd5;
  localparam logic [2:0] REG_TRANS  = 3'd6;

  localparam int NST = 1 + DIV_STEPS + 3 + 2;  // pipeline registers

  localparam logic [16:0] COL_LIM = 17'(MAX_COLUMNS - 1);
  localparam logic [16:0] ROW_LIM = 17'(MAX_ROWS - 1);

  typedef struct packed {
    logic [DIV_STEPS-1:0] z;
    logic                 clr;
    logic [7:0]           blue;
    logic [7:0]           green;
    logic [7:0]           red;
  } pass_t;

  typedef struct packed {
    logic signed [WORLD_W-1:0] x;
    logic signed [WORLD_W-1:0] y;
    logic signed [WORLD_W-1:0] z;
    logic [7:0]                blue;
    logic [7:0]                green;
    logic [7:0]                red;
    logic                      clr;
  } res_t;

  // configuration registers
  logic [63:0] intr_x_r, intr_y_r;
  logic [23:0] min_id_r;
  logic [47:0] rot0_r, rot1_r, rot2_r;
  logic [59:0] trans_r;
  logic        wr;
  logic [2:0]  widx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign widx   = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intr_x_r <= 64'd1073741824;
      intr_y_r <= 64'd1073741824;
      min_id_r <= '0;
      rot0_r   <= 48'd16384;
      rot1_r   <= 48'd1073741824;
      rot2_r   <= 48'd70368744177664;
      trans_r  <= '0;
    end else if (wr) begin
      case (widx)
        REG_INTR_X: intr_x_r <= pwdata;
        REG_INTR_Y: intr_y_r <= pwdata;
        REG_MIN_ID: min_id_r <= pwdata[23:0];
        REG_ROT0:   rot0_r   <= pwdata[47:0];
        REG_ROT1:   rot1_r   <= pwdata[47:0];
        REG_ROT2:   rot2_r   <= pwdata[47:0];
        REG_TRANS:  trans_r  <= pwdata[59:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_INTR_X: prdata = intr_x_r;
      REG_INTR_Y: prdata = intr_y_r;
      REG_MIN_ID: prdata = {40'd0, min_id_r};
      REG_ROT0:   prdata = {16'd0, rot0_r};
      REG_ROT1:   prdata = {16'd0, rot1_r};
      REG_ROT2:   prdata = {16'd0, rot2_r};
      REG_TRANS:  prdata = {4'd0, trans_r};
      default:    prdata = '0;
    endcase
  end

  // pipeline moves as one; it halts only while the skid register is full
  logic           en;
  logic [NST-1:0] v_r;
  logic           skid_v_r, out_v_r;
  res_t           skid_r, out_r, last;

  assign en       = ~skid_v_r;
  assign in_stall = skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  // entry stage: clamp coordinates, threshold test, intrinsics products
  logic [11:0]           u_c, v_c;
  logic signed [44:0]    px, py;
  logic signed [A_W-1:0] ax, ay;
  div_t                  div_s [DIV_STEPS+1];
  div_t                  ent_nxt, ent_r;

  always_comb begin
    u_c = ({5'd0, in_pixel_column} > COL_LIM) ? COL_LIM[11:0] : in_pixel_column;
    v_c = ({5'd0, in_pixel_row} > ROW_LIM) ? ROW_LIM[11:0] : in_pixel_row;
    px  = $signed(intr_x_r[31:0]) * $signed({1'b0, u_c});
    py  = $signed(intr_y_r[31:0]) * $signed({1'b0, v_c});
    ax  = {px[44], px} + A_W'($signed(intr_x_r[63:32]));
    ay  = {py[44], py} + A_W'($signed(intr_y_r[63:32]));
    // divider starts with the leading dividend bit already shifted in
    ent_nxt.rem        = REM_W'(1);
    ent_nxt.d          = in_inverse_depth;
    ent_nxt.q          = '0;
    ent_nxt.side.ax    = ax;
    ent_nxt.side.ay    = ay;
    ent_nxt.side.clr   = in_inverse_depth < min_id_r;
    ent_nxt.side.blue  = in_color_blue;
    ent_nxt.side.green = in_color_green;
    ent_nxt.side.red   = in_color_red;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ent_r <= ent_nxt;
    end
  end

  assign div_s[0] = ent_r;

  // divider chain; zero inverse depth yields all ones, the saturated depth
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    dtwp_div_cell u_cell (
      .clk (clk),
      .en  (en),
      .cur (div_s[k]),
      .res (div_s[k+1])
    );
  end

  // sideband carried alongside back-projection and transform
  div_t                    dend;
  pass_t                   pass_nxt;
  pass_t                   pass_r [5];
  logic signed [CAM_W-1:0] cam_x, cam_y, cam_z;

  always_comb begin
    dend           = div_s[DIV_STEPS];
    pass_nxt.z     = dend.side.clr ? '0 : dend.q;  // below minimum: depth is zero
    pass_nxt.clr   = dend.side.clr;
    pass_nxt.blue  = dend.side.blue;
    pass_nxt.green = dend.side.green;
    pass_nxt.red   = dend.side.red;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pass_r[0] <= pass_nxt;
      for (int i = 1; i < 5; i++) begin
        pass_r[i] <= pass_r[i-1];
      end
    end
  end

  dtwp_backproj u_bp_x (
    .clk (clk),
    .en  (en),
    .a   (dend.side.ax),
    .z   (pass_nxt.z),
    .cam (cam_x)
  );

  dtwp_backproj u_bp_y (
    .clk (clk),
    .en  (en),
    .a   (dend.side.ay),
    .z   (pass_nxt.z),
    .cam (cam_y)
  );

  assign cam_z = $signed({{(CAM_W-DIV_STEPS){1'b0}}, pass_r[2].z});

  logic signed [WORLD_W-1:0] wx, wy, wz;

  dtwp_transform u_tr_x (
    .clk   (clk),
    .en    (en),
    .row   (rot0_r),
    .tr    (trans_r[19:0]),
    .cam_x (cam_x),
    .cam_y (cam_y),
    .cam_z (cam_z),
    .world (wx)
  );

  dtwp_transform u_tr_y (
    .clk   (clk),
    .en    (en),
    .row   (rot1_r),
    .tr    (trans_r[39:20]),
    .cam_x (cam_x),
    .cam_y (cam_y),
    .cam_z (cam_z),
    .world (wy)
  );

  dtwp_transform u_tr_z (
    .clk   (clk),
    .en    (en),
    .row   (rot2_r),
    .tr    (trans_r[59:40]),
    .cam_x (cam_x),
    .cam_y (cam_y),
    .cam_z (cam_z),
    .world (wz)
  );

  always_comb begin
    last.x     = wx;
    last.y     = wy;
    last.z     = wz;
    last.blue  = pass_r[4].blue;
    last.green = pass_r[4].green;
    last.red   = pass_r[4].red;
    last.clr   = pass_r[4].clr;
  end

  // output register with a skid register behind it
  logic take;
  assign take = ~out_v_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (take) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= v_r[NST-1];
      end
    end else if (v_r[NST-1] && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= skid_v_r ? skid_r : last;
    end else if (en) begin
      skid_r <= last;
    end
  end

  assign out_valid         = out_v_r;
  assign out_world_x       = out_r.x;
  assign out_world_y       = out_r.y;
  assign out_world_z       = out_r.z;
  assign out_blue          = out_r.blue;
  assign out_green         = out_r.green;
  assign out_red           = out_r.red;
  assign out_depth_cleared = out_r.clr;

endmodule

@@ sim/dtwp_tb_pkg.sv @@
// register map and result type shared by the depth to world point testbench
package dtwp_tb_pkg;

  typedef enum logic [2:0] {
    REG_INTRINSIC_X = 3'd0,
    REG_INTRINSIC_Y = 3'd1,
    REG_MIN_INV_DEPTH = 3'd2,
    REG_ROT_ROW0 = 3'd3,
    REG_ROT_ROW1 = 3'd4,
    REG_ROT_ROW2 = 3'd5,
    REG_TRANSLATION = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic               cleared;
  } world_point_t;

endpackage

@@ sim/depth_to_world_point_checker.sv @@
// watches the channels of the depth to world point unit, predicts and compares
module depth_to_world_point_checker import dtwp_tb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [11:0] in_pixel_column,
  input  logic [11:0] in_pixel_row,
  input  logic [23:0] in_inverse_depth,
  input  logic [7:0]  in_color_blue,
  input  logic [7:0]  in_color_green,
  input  logic [7:0]  in_color_red,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_world_x,
  input  logic [31:0] out_world_y,
  input  logic [31:0] out_world_z,
  input  logic [7:0]  out_blue,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_red,
  input  logic        out_depth_cleared,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output int          fail_count,
  output int          points_pending,
  output int          points_seen,
  output int          points_cleared
);

  logic [63:0] intr_x, intr_y;
  logic [23:0] min_inv;
  logic [47:0] rot [3];
  logic [59:0] trans;

  // expected points in arrival order, far deeper than the pipeline
  world_point_t points_due [256];
  logic [7:0]   due_wr, due_rd;
  int           due_count;

  // Q.30 coordinate times Q.16 depth, rounded half away from zero, 40-bit sat
  function automatic logic signed [39:0] cam_coord(logic signed [63:0] a, logic [37:0] z);
    logic [127:0] mag;
    logic [127:0] r;
    logic signed [63:0] s;
    mag = (a < 0) ? 128'(-a) : 128'(a);
    r = (mag * 128'(z) + (128'd1 << 29)) >> 30;
    if (a < 0) begin
      if (r > (128'd1 << 39)) r = 128'd1 << 39;
      s = -$signed(r[63:0]);
    end else begin
      if (r > (128'd1 << 39) - 1) r = (128'd1 << 39) - 1;
      s = $signed(r[63:0]);
    end
    return s[39:0];
  endfunction

  // one rotation row dotted with the camera point plus translation, Q16.16 sat
  function automatic logic signed [31:0] world_axis(logic [47:0] row,
      logic signed [39:0] c0, logic signed [39:0] c1, logic signed [39:0] c2,
      logic [19:0] t);
    logic signed [127:0] acc;
    logic signed [127:0] tt;
    acc = $signed(row[15:0]) * c0;
    acc = acc + $signed(row[31:16]) * c1;
    acc = acc + $signed(row[47:32]) * c2;
    tt = $signed(t);
    acc = acc + (tt <<< 18);
    acc = (acc + 128'sd8192) >>> 14;
    if (acc > 128'sd2147483647) acc = 128'sd2147483647;
    if (acc < -128'sd2147483648) acc = -128'sd2147483648;
    return acc[31:0];
  endfunction

  function automatic world_point_t predict_point(logic [11:0] u_in, logic [11:0] v_in,
      logic [23:0] d, logic [7:0] b, logic [7:0] g, logic [7:0] r);
    world_point_t p;
    logic [12:0] u, v;
    logic [37:0] z;
    logic signed [63:0] ax, ay;
    logic signed [39:0] cx, cy, cz;
    u = {1'b0, u_in};
    v = {1'b0, v_in};
    if (u > dtwp_pkg::MAX_COLUMNS - 1) u = 13'(dtwp_pkg::MAX_COLUMNS - 1);
    if (v > dtwp_pkg::MAX_ROWS - 1) v = 13'(dtwp_pkg::MAX_ROWS - 1);
    p.cleared = d < min_inv;
    if (p.cleared) z = '0;
    else if (d == 0) z = (38'd1 << 37) - 1;
    else z = 38'((64'd1 << 36) / d);
    ax = $signed(intr_x[31:0]) * $signed(u) + $signed(intr_x[63:32]);
    ay = $signed(intr_y[31:0]) * $signed(v) + $signed(intr_y[63:32]);
    cx = cam_coord(ax, z);
    cy = cam_coord(ay, z);
    cz = $signed({2'b0, z});
    p.world_x = world_axis(rot[0], cx, cy, cz, trans[19:0]);
    p.world_y = world_axis(rot[1], cx, cy, cz, trans[39:20]);
    p.world_z = world_axis(rot[2], cx, cy, cz, trans[59:40]);
    p.blue = b;
    p.green = g;
    p.red = r;
    return p;
  endfunction

  always @(posedge clk) begin
    world_point_t got, want;
    logic push, pop;
    if (!rst_n) begin
      intr_x <= 64'd1073741824;
      intr_y <= 64'd1073741824;
      min_inv <= '0;
      rot[0] <= 48'd16384;
      rot[1] <= 48'd1073741824;
      rot[2] <= 48'd1 << 46;
      trans <= '0;
      due_wr <= '0;
      due_rd <= '0;
      due_count <= 0;
      fail_count <= 0;
      points_seen <= 0;
      points_cleared <= 0;
    end else begin
      push = in_valid && !in_stall;
      pop = 1'b0;
      // register shadow; writes must land only while the unit is idle, the checker does not enforce it
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[5:3]))
          REG_INTRINSIC_X:   intr_x <= pwdata;
          REG_INTRINSIC_Y:   intr_y <= pwdata;
          REG_MIN_INV_DEPTH: min_inv <= pwdata[23:0];
          REG_ROT_ROW0:      rot[0] <= pwdata[47:0];
          REG_ROT_ROW1:      rot[1] <= pwdata[47:0];
          REG_ROT_ROW2:      rot[2] <= pwdata[47:0];
          REG_TRANSLATION:   trans <= pwdata[59:0];
          default: ;
        endcase
      end
      if (push) begin
        points_due[due_wr] <= predict_point(in_pixel_column, in_pixel_row,
                                            in_inverse_depth, in_color_blue,
                                            in_color_green, in_color_red);
        due_wr <= due_wr + 8'd1;
      end
      if (out_valid && !out_stall) begin
        got = '{out_world_x, out_world_y, out_world_z, out_blue, out_green, out_red,
                out_depth_cleared};
        points_seen <= points_seen + 1;
        if (out_depth_cleared) points_cleared <= points_cleared + 1;
        if (due_count == 0) begin
          if (fail_count < 10) $display("unexpected world point %p", got);
          fail_count <= fail_count + 1;
        end else begin
          pop = 1'b1;
          want = points_due[due_rd];
          due_rd <= due_rd + 8'd1;
          if (got !== want) begin
            if (fail_count < 10)
              $display("point mismatch: expected %p, got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      due_count <= due_count + int'(push) - int'(pop);
    end
  end

  assign points_pending = due_count;

endmodule

@@ sim/depth_to_world_point_unit_tb.sv @@
// stimulus and verdict for the depth to world point unit
module depth_to_world_point_unit_tb import dtwp_tb_pkg::*;;

  localparam int PHASE_ITEMS = 330;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;   // longer than the pipeline latency

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [11:0] in_pixel_column, in_pixel_row;
  logic [23:0] in_inverse_depth;
  logic [7:0] in_color_blue, in_color_green, in_color_red;
  logic out_valid, out_stall;
  logic signed [31:0] out_world_x, out_world_y, out_world_z;
  logic [7:0] out_blue, out_green, out_red;
  logic out_depth_cleared;
  logic psel, penable, pwrite, pready;
  logic [5:0] paddr;
  logic [63:0] pwdata, prdata;

  int fail_count, points_pending, points_seen, points_cleared;
  int cycle_count = 0;
  int items_sent;
  bit gaps_on;        // random idling on both sides, off for the last phase
  logic [23:0] min_inv_now;

  depth_to_world_point_unit i_dut (.*);

  depth_to_world_point_checker i_checker (.*);

  // free-running clock, period 4
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop if the unit hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver back-pressure in random bursts
  initial begin
    out_stall = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // register write: setup phase, access phase, then idle
  task automatic reg_write(reg_idx_t idx, logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_MIN_INV_DEPTH) min_inv_now = value[23:0];
    @(posedge clk);
  endtask

  // hand one pixel to the unit, maybe after a sender gap
  task automatic push_pixel(logic [11:0] u, logic [11:0] v, logic [23:0] d);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_column <= u;
    in_pixel_row <= v;
    in_inverse_depth <= d;
    in_color_blue <= 8'($urandom);
    in_color_green <= 8'($urandom);
    in_color_red <= 8'($urandom);
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // wait for the pipeline to empty before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (points_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // inverse depth mix: zero, around the threshold, tiny, max, anything
  function automatic logic [23:0] pick_depth();
    logic [23:0] d;
    case ($urandom_range(0, 9))
      0: d = '0;
      1: d = min_inv_now - 24'(1);
      2: d = min_inv_now;
      3: d = min_inv_now + 24'(1);
      4: d = 24'($urandom_range(1, 255));
      5: d = 24'hffffff;
      default: d = 24'($urandom);
    endcase
    return d;
  endfunction

  initial begin
    logic [63:0] rnd [7];
    items_sent = 0;
    gaps_on = 1'b1;
    min_inv_now = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel_column = '0;
    in_pixel_row = '0;
    in_inverse_depth = '0;
    in_color_blue = '0;
    in_color_green = '0;
    in_color_red = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners at reset defaults: frame edges, zero and extreme depth
    push_pixel(12'd0, 12'd0, 24'd0);
    push_pixel(12'hfff, 12'hfff, 24'd0);
    push_pixel(12'd0, 12'hfff, 24'd1);
    push_pixel(12'hfff, 12'd0, 24'hffffff);
    push_pixel(12'h555, 12'haaa, 24'h100000);
    push_pixel(12'haaa, 12'h555, 24'h800000);
    push_pixel(12'd1, 12'd1, 24'd3);
    settle();

    // pinhole-like camera, threshold set, y axis flipped and offset
    reg_write(REG_INTRINSIC_X, {32'hffc00000, 32'h00200000});
    reg_write(REG_INTRINSIC_Y, {32'hffd00000, 32'h00200000});
    reg_write(REG_MIN_INV_DEPTH, 64'h001000);
    reg_write(REG_ROT_ROW0, {16'h0000, 16'h0000, 16'h4000});
    reg_write(REG_ROT_ROW1, {16'h0000, 16'hc000, 16'h0000});
    reg_write(REG_ROT_ROW2, {16'h4000, 16'h0000, 16'h0000});
    reg_write(REG_TRANSLATION, {20'h01000, 20'hff000, 20'h00800});
    // below minimum, at minimum, zero inverse depth now cleared
    push_pixel(12'd100, 12'd200, 24'h000fff);
    push_pixel(12'd100, 12'd200, 24'h001000);
    push_pixel(12'd0, 12'd0, 24'd0);
    push_pixel(12'hfff, 12'hfff, 24'h001001);
    push_pixel(12'd320, 12'd240, 24'h0fffff);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      push_pixel(12'($urandom), 12'($urandom), pick_depth());
      // once mid phase, hold the sender until every point is back
      if (n == PHASE_ITEMS / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (points_pending != 0) @(posedge clk);
      end
    end
    settle();

    // every register at all ones, then at mixed most negative and most positive patterns
    foreach (rnd[k]) reg_write(reg_idx_t'(k), '1);
    push_pixel(12'hfff, 12'hfff, 24'hffffff);
    for (int n = 0; n < PHASE_ITEMS; n++)
      push_pixel(12'($urandom), 12'($urandom), pick_depth());
    settle();
    reg_write(REG_INTRINSIC_X, {32'h80000000, 32'h80000000});
    reg_write(REG_INTRINSIC_Y, {32'h7fffffff, 32'h7fffffff});
    reg_write(REG_MIN_INV_DEPTH, 64'd0);
    reg_write(REG_ROT_ROW0, {3{16'h8000}});
    reg_write(REG_ROT_ROW1, {3{16'h7fff}});
    reg_write(REG_ROT_ROW2, {16'h8000, 16'h7fff, 16'h8000});
    reg_write(REG_TRANSLATION, {20'h80000, 20'h7ffff, 20'h80000});
    push_pixel(12'd0, 12'd0, 24'd0);
    push_pixel(12'hfff, 12'hfff, 24'd0);
    for (int n = 0; n < PHASE_ITEMS; n++)
      push_pixel(12'($urandom), 12'($urandom), pick_depth());
    settle();

    // random settings with a small threshold, last of them without any idling
    for (int ph = 0; ph < 3; ph++) begin
      foreach (rnd[k]) rnd[k] = {$urandom, $urandom};
      rnd[REG_MIN_INV_DEPTH] = 64'($urandom_range(0, 24'h00ffff));
      foreach (rnd[k]) reg_write(reg_idx_t'(k), rnd[k]);
      if (ph == 2) gaps_on = 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++)
        push_pixel(12'($urandom), 12'($urandom), pick_depth());
      settle();
    end

    $display("sent %0d pixels over seven register settings, %0d points checked",
             items_sent, points_seen);
    $display("%0d points had depth cleared below the threshold", points_cleared);
    if (fail_count == 0 && points_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d points never arrived", fail_count, points_pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
